// ===== src/mmas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_pkg
// Shared types and constants for the 4x4 fixed-point matrix unit: the
// function codes, the control word that travels down the cell chain and
// the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package mmas_pkg;

  // fixed port widths
  localparam int FIELD_W = 32;
  localparam int ROW_W   = 2;
  localparam int FUNC_W  = 2;

  // matrix geometry: one cell per stored row
  localparam int N_ROWS = 4;
  localparam int N_COLS = 4;

  // function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_MUL  = 2'd1,
    FUNC_ADD  = 2'd2,
    FUNC_SUB  = 2'd3
  } mmas_func_e;

  // control that rides along with each word
  typedef struct packed {
    mmas_func_e        func;
    logic [ROW_W-1:0]  row;
  } mmas_ctl_t;

endpackage
`default_nettype wire

// ===== src/mmas_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_cell
// One link of the chain. Holds one stored row of the right-hand matrix,
// forms the four products of its left-hand element with that row, folds
// the previous cell's products into the running sums, and does the
// saturating add or subtract when the word targets its row.
// ----------------------------------------------------------------------------
module mmas_cell #(
  parameter int                ELEM_W   = 32,
  parameter int                CELL_IDX = 0,
  parameter logic [ELEM_W-1:0] UNIT_VAL = '0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // upstream side
  input  logic                          up_valid_i,
  output logic                          up_stall_o,
  input  mmas_pkg::mmas_ctl_t           up_ctl_i,
  input  logic signed [ELEM_W-1:0]      up_elem_i [mmas_pkg::N_COLS],
  input  logic signed [2*ELEM_W+1:0]    up_acc_i  [mmas_pkg::N_COLS],
  input  logic signed [2*ELEM_W-1:0]    up_prod_i [mmas_pkg::N_COLS],
  input  logic signed [ELEM_W-1:0]      up_res_i  [mmas_pkg::N_COLS],
  // downstream side
  output logic                          dn_valid_o,
  input  logic                          dn_stall_i,
  output mmas_pkg::mmas_ctl_t           dn_ctl_o,
  output logic signed [ELEM_W-1:0]      dn_elem_o [mmas_pkg::N_COLS],
  output logic signed [2*ELEM_W+1:0]    dn_acc_o  [mmas_pkg::N_COLS],
  output logic signed [2*ELEM_W-1:0]    dn_prod_o [mmas_pkg::N_COLS],
  output logic signed [ELEM_W-1:0]      dn_res_o  [mmas_pkg::N_COLS]
);
  import mmas_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + 2;

  logic                     valid_q;
  mmas_ctl_t                ctl_q;
  logic signed [ELEM_W-1:0] elem_q [N_COLS];
  logic signed [ACC_W-1:0]  acc_q  [N_COLS];
  logic signed [PROD_W-1:0] prod_q [N_COLS];
  logic signed [ELEM_W-1:0] res_q  [N_COLS];
  logic signed [ELEM_W-1:0] row_q  [N_COLS];

  logic signed [ACC_W-1:0]  acc_d  [N_COLS];
  logic signed [PROD_W-1:0] prod_d [N_COLS];
  logic signed [ELEM_W-1:0] res_d  [N_COLS];
  logic signed [ELEM_W:0]   as_sum [N_COLS];

  logic take;
  logic hit;
  logic is_addsub;

  // handshake: the stage moves unless it is full and blocked below
  assign up_stall_o = valid_q & dn_stall_i;
  assign take       = up_valid_i & ~up_stall_o;
  assign hit        = (up_ctl_i.row == ROW_W'(CELL_IDX));
  assign is_addsub  = (up_ctl_i.func == FUNC_ADD) || (up_ctl_i.func == FUNC_SUB);

  // products with the stored row, running sums, add/sub on the target row
  always_comb begin
    for (int j = 0; j < N_COLS; j++) begin
      prod_d[j] = up_elem_i[CELL_IDX] * row_q[j];
      acc_d[j]  = up_acc_i[j] + ACC_W'(up_prod_i[j]);
      if (up_ctl_i.func == FUNC_SUB) begin
        as_sum[j] = (ELEM_W+1)'(up_elem_i[j]) - (ELEM_W+1)'(row_q[j]);
      end else begin
        as_sum[j] = (ELEM_W+1)'(up_elem_i[j]) + (ELEM_W+1)'(row_q[j]);
      end
      if (hit && is_addsub) begin
        if (as_sum[j][ELEM_W] != as_sum[j][ELEM_W-1]) begin
          res_d[j] = {as_sum[j][ELEM_W], {(ELEM_W-1){~as_sum[j][ELEM_W]}}};
        end else begin
          res_d[j] = as_sum[j][ELEM_W-1:0];
        end
      end else begin
        res_d[j] = up_res_i[j];
      end
    end
  end

  // stored row, identity on reset, replaced by a load word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N_COLS; j++) begin
        row_q[j] <= (j == CELL_IDX) ? UNIT_VAL : '0;
      end
    end else if (take && hit && (up_ctl_i.func == FUNC_LOAD)) begin
      for (int j = 0; j < N_COLS; j++) begin
        row_q[j] <= up_elem_i[j];
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!up_stall_o) begin
      valid_q <= up_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      ctl_q <= up_ctl_i;
      for (int j = 0; j < N_COLS; j++) begin
        elem_q[j] <= up_elem_i[j];
        acc_q[j]  <= acc_d[j];
        prod_q[j] <= prod_d[j];
        res_q[j]  <= res_d[j];
      end
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_ctl_o   = ctl_q;
  assign dn_elem_o  = elem_q;
  assign dn_acc_o   = acc_q;
  assign dn_prod_o  = prod_q;
  assign dn_res_o   = res_q;

endmodule
`default_nettype wire

// ===== src/mmas_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_out
// End of the chain. Adds the last cell's products into the sums, shifts
// them down by the fraction width with floor rounding, saturates, picks
// the multiply or add/sub result and holds it in the output register.
// Load words end here without a result.
// ----------------------------------------------------------------------------
module mmas_out #(
  parameter int ELEM_W    = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // from the last cell
  input  logic                          up_valid_i,
  output logic                          up_stall_o,
  input  mmas_pkg::mmas_ctl_t           up_ctl_i,
  input  logic signed [2*ELEM_W+1:0]    up_acc_i  [mmas_pkg::N_COLS],
  input  logic signed [2*ELEM_W-1:0]    up_prod_i [mmas_pkg::N_COLS],
  input  logic signed [ELEM_W-1:0]      up_res_i  [mmas_pkg::N_COLS],
  // result side
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mmas_pkg::ROW_W-1:0]    out_row_o,
  output logic signed [ELEM_W-1:0]      out_data_o [mmas_pkg::N_COLS]
);
  import mmas_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + 2;

  logic                     valid_q;
  logic [ROW_W-1:0]         row_q;
  logic signed [ELEM_W-1:0] data_q [N_COLS];

  logic signed [ACC_W-1:0]  sum    [N_COLS];
  logic signed [ACC_W-1:0]  shf    [N_COLS];
  logic signed [ELEM_W-1:0] data_d [N_COLS];
  logic                     take;

  assign up_stall_o = valid_q & out_stall_i;
  assign take       = up_valid_i & ~up_stall_o;

  // final sum, floor shift and saturation
  always_comb begin
    for (int j = 0; j < N_COLS; j++) begin
      sum[j] = up_acc_i[j] + ACC_W'(up_prod_i[j]);
      shf[j] = sum[j] >>> FRAC_BITS;
      if (up_ctl_i.func != FUNC_MUL) begin
        data_d[j] = up_res_i[j];
      end else if ((&shf[j][ACC_W-1:ELEM_W-1]) || !(|shf[j][ACC_W-1:ELEM_W-1])) begin
        data_d[j] = shf[j][ELEM_W-1:0];
      end else begin
        data_d[j] = {shf[j][ACC_W-1], {(ELEM_W-1){~shf[j][ACC_W-1]}}};
      end
    end
  end

  // output valid, loads leave no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!up_stall_o) begin
      valid_q <= up_valid_i && (up_ctl_i.func != FUNC_LOAD);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q <= up_ctl_i.row;
      for (int j = 0; j < N_COLS; j++) begin
        data_q[j] <= data_d[j];
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_row_o   = row_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

// ===== src/matrix4x4_mul_add_sub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted word passes the four cell registers, then the output register.
// Throughput: one word per cycle while the result side does not stall; four cells, one per stored row, each does
// the four multiplies of its row, and the output stage does the final sum.
// Stall from the result side backs up stage by stage; bubbles are squeezed.
// Reset: stored matrix returns to identity at once, pipeline empties.
// ----------------------------------------------------------------------------
// matrix4x4_mul_add_sub
// 4x4 signed fixed-point matrix unit with a stored right-hand matrix.
// Multiply, add and subtract words each carry one left-hand row; load
// words replace a stored row.
// ----------------------------------------------------------------------------
module matrix4x4_mul_add_sub #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [mmas_pkg::FUNC_W-1:0]          func_i,
  input  logic [mmas_pkg::ROW_W-1:0]           row_index_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_0_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_1_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_2_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_3_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mmas_pkg::ROW_W-1:0]           result_row_o,
  output logic signed [mmas_pkg::FIELD_W-1:0]  out_0_o,
  output logic signed [mmas_pkg::FIELD_W-1:0]  out_1_o,
  output logic signed [mmas_pkg::FIELD_W-1:0]  out_2_o,
  output logic signed [mmas_pkg::FIELD_W-1:0]  out_3_o
);
  import mmas_pkg::*;

  // element width actually kept, limited by the port fields
  localparam int EFF_W  = (ELEM_WIDTH > FIELD_W) ? FIELD_W : ELEM_WIDTH;
  localparam int PROD_W = 2 * EFF_W;
  localparam int ACC_W  = PROD_W + 2;

  // one in fixed point, clipped to the largest element if it does not fit
  localparam logic [EFF_W-1:0] UNIT = (FRAC_BITS >= EFF_W - 1) ?
                                      {1'b0, {(EFF_W-1){1'b1}}} :
                                      (EFF_W'(1) << FRAC_BITS);

  logic                    lnk_valid [N_ROWS+1];
  logic                    lnk_stall [N_ROWS+1];
  mmas_ctl_t               lnk_ctl   [N_ROWS+1];
  logic signed [EFF_W-1:0] lnk_elem  [N_ROWS][N_COLS];
  logic signed [ACC_W-1:0] lnk_acc   [N_ROWS+1][N_COLS];
  logic signed [PROD_W-1:0] lnk_prod [N_ROWS+1][N_COLS];
  logic signed [EFF_W-1:0] lnk_res   [N_ROWS+1][N_COLS];
  logic signed [EFF_W-1:0] out_data  [N_COLS];

  // head of the chain from the input ports
  assign lnk_valid[0]   = in_valid_i;
  assign in_stall_o     = lnk_stall[0];
  assign lnk_ctl[0]     = '{func: mmas_func_e'(func_i), row: row_index_i};
  assign lnk_elem[0][0] = elem_0_i[EFF_W-1:0];
  assign lnk_elem[0][1] = elem_1_i[EFF_W-1:0];
  assign lnk_elem[0][2] = elem_2_i[EFF_W-1:0];
  assign lnk_elem[0][3] = elem_3_i[EFF_W-1:0];

  always_comb begin
    for (int j = 0; j < N_COLS; j++) begin
      lnk_acc[0][j]  = '0;
      lnk_prod[0][j] = '0;
      lnk_res[0][j]  = '0;
    end
  end

  // chain of row cells
  for (genvar k = 0; k < N_ROWS; k++) begin : g_cell
    if (k < N_ROWS - 1) begin : g_mid
      mmas_cell #(
        .ELEM_W   (EFF_W),
        .CELL_IDX (k),
        .UNIT_VAL (UNIT)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .up_valid_i (lnk_valid[k]),
        .up_stall_o (lnk_stall[k]),
        .up_ctl_i   (lnk_ctl[k]),
        .up_elem_i  (lnk_elem[k]),
        .up_acc_i   (lnk_acc[k]),
        .up_prod_i  (lnk_prod[k]),
        .up_res_i   (lnk_res[k]),
        .dn_valid_o (lnk_valid[k+1]),
        .dn_stall_i (lnk_stall[k+1]),
        .dn_ctl_o   (lnk_ctl[k+1]),
        .dn_elem_o  (lnk_elem[k+1]),
        .dn_acc_o   (lnk_acc[k+1]),
        .dn_prod_o  (lnk_prod[k+1]),
        .dn_res_o   (lnk_res[k+1])
      );
    end else begin : g_last
      // the elements are no longer needed past the last cell
      mmas_cell #(
        .ELEM_W   (EFF_W),
        .CELL_IDX (k),
        .UNIT_VAL (UNIT)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .up_valid_i (lnk_valid[k]),
        .up_stall_o (lnk_stall[k]),
        .up_ctl_i   (lnk_ctl[k]),
        .up_elem_i  (lnk_elem[k]),
        .up_acc_i   (lnk_acc[k]),
        .up_prod_i  (lnk_prod[k]),
        .up_res_i   (lnk_res[k]),
        .dn_valid_o (lnk_valid[k+1]),
        .dn_stall_i (lnk_stall[k+1]),
        .dn_ctl_o   (lnk_ctl[k+1]),
        .dn_elem_o  (),
        .dn_acc_o   (lnk_acc[k+1]),
        .dn_prod_o  (lnk_prod[k+1]),
        .dn_res_o   (lnk_res[k+1])
      );
    end
  end

  // final sum, rounding and output register
  mmas_out #(
    .ELEM_W    (EFF_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (lnk_valid[N_ROWS]),
    .up_stall_o  (lnk_stall[N_ROWS]),
    .up_ctl_i    (lnk_ctl[N_ROWS]),
    .up_acc_i    (lnk_acc[N_ROWS]),
    .up_prod_i   (lnk_prod[N_ROWS]),
    .up_res_i    (lnk_res[N_ROWS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (result_row_o),
    .out_data_o  (out_data)
  );

  // sign-extend results to the port width
  assign out_0_o = FIELD_W'(out_data[0]);
  assign out_1_o = FIELD_W'(out_data[1]);
  assign out_2_o = FIELD_W'(out_data[2]);
  assign out_3_o = FIELD_W'(out_data[3]);

endmodule
`default_nettype wire

// ===== src/mmas_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmas_chk
// Port-level checks for the matrix unit: result channel holds under
// stall, and the path from input word through the cell and output registers to result word.
// ----------------------------------------------------------------------------
module mmas_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_o,
  input  logic [mmas_pkg::FUNC_W-1:0]          func_i,
  input  logic [mmas_pkg::ROW_W-1:0]           row_index_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_0_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_1_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_2_i,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  elem_3_i,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic [mmas_pkg::ROW_W-1:0]           result_row_o,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  out_0_o,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  out_1_o,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  out_2_o,
  input  logic signed [mmas_pkg::FIELD_W-1:0]  out_3_o
);
  import mmas_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_row_o) && $stable(out_0_o) &&
      $stable(out_1_o) && $stable(out_2_o) && $stable(out_3_o))
    else $error("result payload changed while stalled");

  // compute word shows up as a result word with its row on a free-running output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (func_i != FUNC_LOAD) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o && (result_row_o == $past(row_index_i, 5)))
    else $error("result word missing or row mismatch after five cycles");

  // load word leaves no result in its slot
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (func_i == FUNC_LOAD) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i
    |=> !out_valid_o)
    else $error("load word produced a result");

endmodule

bind matrix4x4_mul_add_sub mmas_chk u_mmas_chk (.*);
`default_nettype wire

// ===== verif/tb_matrix4x4_mul_add_sub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_mul_add_sub
// Self-checking bench for the 4x4 fixed-point matrix unit. A scoreboard
// keeps its own copy of the stored right-hand matrix and computes the
// expected result word for every multiply, add and subtract word that the
// block accepts; load words only update that copy. Directed edge cases
// come first, then random rows with random idling on both channels, a long
// receiver hold-off that backs the pipeline up, and a final burst at full
// rate.
// ----------------------------------------------------------------------------
module tb_matrix4x4_mul_add_sub;
  import mmas_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int ELEM_WIDTH  = 32;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 20;

  // expected rows, built from a private copy of the stored matrix
  class row_scoreboard;
    localparam int EFF_W = (ELEM_WIDTH > 32) ? 32 : ELEM_WIDTH;
    localparam longint ELEM_MAX = (longint'(1) << (EFF_W - 1)) - 1;

    typedef struct packed {
      logic [ROW_W-1:0]              row;
      logic [3:0][FIELD_W-1:0]       val;
    } row_word_t;

    longint    stored[16];
    row_word_t expected_q[$];
    int        errors;

    function new();
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (one > ELEM_MAX) one = ELEM_MAX;
      for (int i = 0; i < 16; i++) stored[i] = ((i >> 2) == (i & 3)) ? one : 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // low EFF_W bits of the field, sign-extended
    function longint sext(logic [FIELD_W-1:0] raw);
      longint m;
      m = longint'(raw) & ((longint'(1) << EFF_W) - 1);
      if (((m >> (EFF_W - 1)) & 1) != 0) m = m - (longint'(1) << EFF_W);
      return m;
    endfunction

    // clamp to the element range, sign-extended to the field width
    function logic [FIELD_W-1:0] saturate(logic signed [67:0] v);
      logic signed [67:0] hi;
      logic signed [67:0] lo;
      hi = 68'(ELEM_MAX);
      lo = 68'(-ELEM_MAX - 1);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[FIELD_W-1:0];
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task note_input(mmas_func_e f, logic [ROW_W-1:0] r, logic [3:0][FIELD_W-1:0] raw);
      longint             e[4];
      longint             p;
      logic signed [67:0] acc;
      row_word_t          w;
      int                 base;
      base = int'(r) * 4;
      for (int j = 0; j < 4; j++) e[j] = sext(raw[j]);
      if (f == FUNC_LOAD) begin
        for (int j = 0; j < 4; j++) stored[base + j] = e[j];
        return;
      end
      w.row = r;
      for (int j = 0; j < 4; j++) begin
        case (f)
          FUNC_MUL: begin
            // exact sum of products, then floor shift
            acc = '0;
            for (int k = 0; k < 4; k++) begin
              p = e[k] * stored[k * 4 + j];
              acc = acc + 68'(p);
            end
            w.val[j] = saturate(acc >>> FRAC_BITS);
          end
          FUNC_ADD: w.val[j] = saturate(68'(e[j] + stored[base + j]));
          default:  w.val[j] = saturate(68'(e[j] - stored[base + j]));
        endcase
      end
      expected_q.push_back(w);
    endtask

    task check_result(logic [ROW_W-1:0] r, logic [3:0][FIELD_W-1:0] got);
      row_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("result word row %0d with none expected", r));
        return;
      end
      w = expected_q.pop_front();
      if (r !== w.row) report($sformatf("result_row got %0d exp %0d", r, w.row));
      for (int j = 0; j < 4; j++) begin
        if (got[j] !== w.val[j])
          report($sformatf("row %0d out_%0d got %h exp %h", w.row, j, got[j], w.val[j]));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [FUNC_W-1:0]          func_i;
  logic [ROW_W-1:0]           row_index_i;
  logic signed [FIELD_W-1:0]  elem_0_i;
  logic signed [FIELD_W-1:0]  elem_1_i;
  logic signed [FIELD_W-1:0]  elem_2_i;
  logic signed [FIELD_W-1:0]  elem_3_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [ROW_W-1:0]           result_row_o;
  logic signed [FIELD_W-1:0]  out_0_o;
  logic signed [FIELD_W-1:0]  out_1_o;
  logic signed [FIELD_W-1:0]  out_2_o;
  logic signed [FIELD_W-1:0]  out_3_o;

  row_scoreboard sb = new();

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  matrix4x4_mul_add_sub #(
    .FRAC_BITS (FRAC_BITS),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .row_index_i (row_index_i),
    .elem_0_i    (elem_0_i),
    .elem_1_i    (elem_1_i),
    .elem_2_i    (elem_2_i),
    .elem_3_i    (elem_3_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_row_o(result_row_o),
    .out_0_o     (out_0_o),
    .out_1_o     (out_1_o),
    .out_2_o     (out_2_o),
    .out_3_o     (out_3_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watch both channels; inputs noted before results at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_input(mmas_func_e'(func_i), row_index_i,
                      {elem_3_i, elem_2_i, elem_1_i, elem_0_i});
      if (out_valid_o && !out_stall_i)
        sb.check_result(result_row_o, {out_3_o, out_2_o, out_1_o, out_0_o});
    end
  end

  // result side: random stall bursts, and a long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  // offer one word and hold it until taken, then maybe idle a while
  task send_word(mmas_func_e f, logic [ROW_W-1:0] r,
                 logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                 logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d);
    in_valid_i  <= 1'b1;
    func_i      <= f;
    row_index_i <= r;
    elem_0_i    <= a;
    elem_1_i    <= b;
    elem_2_i    <= c;
    elem_3_i    <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // mix of full-range, extreme and small Q16.16 values
  function logic [FIELD_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return $urandom_range(0, 3) == 0 ? 32'hffff_0000 : 32'h0001_0000;
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  task send_random();
    mmas_func_e f;
    if ($urandom_range(0, 4) == 0) f = FUNC_LOAD;
    else f = mmas_func_e'($urandom_range(1, 3));
    send_word(f, ROW_W'($urandom_range(0, 3)), rand_elem(), rand_elem(), rand_elem(),
              rand_elem());
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // give up if the run hangs
  initial begin
    #5ms;
    $display("FAIL matrix4x4_mul_add_sub");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_LOAD;
    row_index_i <= '0;
    elem_0_i    <= '0;
    elem_1_i    <= '0;
    elem_2_i    <= '0;
    elem_3_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity after reset, add/sub saturation at both ends
    send_word(FUNC_MUL, 2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1);
    send_word(FUNC_MUL, 2'd1, 32'hffff_ffff, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_word(FUNC_ADD, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(FUNC_SUB, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(FUNC_ADD, 2'd2, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0);
    send_word(FUNC_SUB, 2'd3, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h8000_0000);
    // replace every stored row with extremes and tiny values
    send_word(FUNC_LOAD, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    send_word(FUNC_LOAD, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_word(FUNC_LOAD, 2'd2, 32'h1, 32'hffff_ffff, 32'h0, 32'h0001_0000);
    send_word(FUNC_LOAD, 2'd3, 32'hffff_ffff, 32'h0, 32'h0001_0000, 32'h8000_0000);
    // product sums past the element range in both directions
    send_word(FUNC_MUL, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(FUNC_MUL, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(FUNC_MUL, 2'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    // floor of tiny positive and negative fractions
    send_word(FUNC_MUL, 2'd3, 32'h0, 32'h0, 32'h1, 32'h0);
    send_word(FUNC_MUL, 2'd0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0);
    send_word(FUNC_MUL, 2'd1, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    // add/sub against loaded rows
    send_word(FUNC_ADD, 2'd1, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0);
    send_word(FUNC_SUB, 2'd0, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0);
    send_word(FUNC_SUB, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(FUNC_ADD, 2'd3, 32'h1, 32'h1, 32'h1, 32'h1);
    wait_drained();

    // random rows with idling on both sides
    repeat (450) send_random();

    // hold the result side off while words keep coming in
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (60) send_random();
    wait_drained();
    idle_on = 1'b1;

    repeat (300) send_random();

    // full rate to the end
    idle_on = 1'b0;
    repeat (200) send_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("PASS matrix4x4_mul_add_sub");
    end else begin
      $display("FAIL matrix4x4_mul_add_sub");
    end
    $finish;
  end

endmodule
